// ===== rtl/stbs_pkg.sv =====
// Shared constants and controller/datapath types for the sorted table search block.
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BITS_DEF    = 32;

  localparam int POS_BITS       = 11;
  localparam int LEN_BITS       = 11;
  localparam int KEY_VALUE_BITS = 32;
  localparam int SRCH_BITS      = POS_BITS + 1;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [APB_ADDR_BITS-1:0] REG_TABLE_LENGTH = 3'h0;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic write_key;
    logic start;
    logic probe;
    logic step;
    logic result_load;
  } stbs_cmd_t;

  typedef struct packed {
    logic in_range;
    logic equal;
  } stbs_status_t;

endpackage

// ===== rtl/stbs_req_if.sv =====
// Request channel: load or search transfer.
interface stbs_req_if;
  import stbs_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic        [POS_BITS-1:0]       entry_position;
  logic signed [KEY_VALUE_BITS-1:0] key_value;

  modport source (output valid, output req_type, output entry_position, output key_value,
                  input ready);
  modport sink   (input valid, input req_type, input entry_position, input key_value,
                  output ready);
endinterface

// ===== rtl/stbs_rsp_if.sv =====
// Response channel: search result transfer.
interface stbs_rsp_if;
  import stbs_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [POS_BITS-1:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

// ===== rtl/stbs_apb_regs.sv =====
// APB configuration register: table_length.
module stbs_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [stbs_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [stbs_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [stbs_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output logic [stbs_pkg::LEN_BITS-1:0]      table_length_o
);
  import stbs_pkg::*;

  logic [LEN_BITS-1:0] len_q, len_d;
  logic                wr_en;

  assign wr_en  = psel && penable && pwrite && (paddr == REG_TABLE_LENGTH);
  assign len_d  = wr_en ? pwdata[LEN_BITS-1:0] : len_q;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TABLE_LENGTH) ? APB_DATA_BITS'(len_q) : '0;
  assign table_length_o = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end
endmodule

// ===== rtl/stbs_datapath.sv =====
// Search datapath: key table memory, low/high/mid bounds, compare and result register.
module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = stbs_pkg::KEY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stbs_pkg::stbs_cmd_t                 cmd_i,
  output stbs_pkg::stbs_status_t              status_o,
  input  logic [stbs_pkg::LEN_BITS-1:0]       table_length_i,
  input  logic [stbs_pkg::POS_BITS-1:0]       entry_position_i,
  input  logic [stbs_pkg::KEY_VALUE_BITS-1:0] key_value_i,
  output logic                                found_o,
  output logic [stbs_pkg::POS_BITS-1:0]       match_position_o
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = (AW > SRCH_BITS) ? AW : SRCH_BITS;

  logic [KEY_BITS-1:0] mem [TABLE_DEPTH];

  logic        [KEY_BITS-1:0]  key_in;
  logic signed [KEY_BITS-1:0]  key_q;
  logic signed [KEY_BITS-1:0]  rdata_q;
  logic        [SRCH_BITS-1:0] low_q, high_q, mid_q;
  logic        [SRCH_BITS-1:0] len_eff, sum_c, mid_c;
  logic        [EW-1:0]        raddr_ext, waddr_ext;
  logic                        write_ok;
  logic                        hit_q;
  logic        [SRCH_BITS-1:0] hit_pos_q;
  logic                        found_q;
  logic        [POS_BITS-1:0]  match_q;

  if (KEY_BITS <= KEY_VALUE_BITS) begin : g_key_trunc
    assign key_in = key_value_i[KEY_BITS-1:0];
  end else begin : g_key_ext
    assign key_in = {{(KEY_BITS-KEY_VALUE_BITS){key_value_i[KEY_VALUE_BITS-1]}}, key_value_i};
  end

  assign len_eff = (32'(table_length_i) > TABLE_DEPTH) ? SRCH_BITS'(TABLE_DEPTH)
                                                       : SRCH_BITS'(table_length_i);
  assign sum_c     = low_q + high_q;
  assign mid_c     = {1'b0, sum_c[SRCH_BITS-1:1]};
  assign raddr_ext = EW'(mid_c) - EW'(1);
  assign waddr_ext = EW'(entry_position_i) - EW'(1);
  assign write_ok  = (entry_position_i != '0) && (32'(entry_position_i) <= TABLE_DEPTH);

  assign status_o.in_range = (low_q <= high_q);
  assign status_o.equal    = (rdata_q == key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_key && write_ok) begin
      mem[waddr_ext[AW-1:0]] <= key_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      rdata_q <= mem[raddr_ext[AW-1:0]];
      mid_q   <= mid_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= key_in;
      low_q  <= SRCH_BITS'(1);
      high_q <= len_eff;
      hit_q  <= 1'b0;
    end else if (cmd_i.step) begin
      if (rdata_q == key_q) begin
        hit_q     <= 1'b1;
        hit_pos_q <= mid_q;
      end else if (rdata_q > key_q) begin
        high_q <= mid_q - SRCH_BITS'(1);
      end else begin
        low_q <= mid_q + SRCH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      match_q <= '0;
    end else if (cmd_i.result_load) begin
      found_q <= hit_q;
      match_q <= hit_q ? hit_pos_q[POS_BITS-1:0] : '0;
    end
  end

  assign found_o          = found_q;
  assign match_position_o = match_q;
endmodule

// ===== rtl/stbs_ctrl.sv =====
// Search controller: request acceptance, probe sequencing and response valid.
module stbs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_type_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  output stbs_pkg::stbs_cmd_t    cmd_o,
  input  stbs_pkg::stbs_status_t status_i
);
  import stbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   rsp_free;

  assign rsp_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == REQ_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PROBE;
          end else begin
            cmd_o.write_key = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.in_range) begin
          cmd_o.probe = 1'b1;
          state_d     = ST_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CHECK: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.equal ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (rsp_free) begin
          cmd_o.result_load = 1'b1;
          rsp_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end
endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted table binary search: top level.
// Usage:
//   req_ch carries load and search transfers. A load (req_type 0) writes
//   key_value at 1-based entry_position and gives no response; positions
//   0 or above TABLE_DEPTH are dropped. A search (req_type 1) runs a halving
//   binary search over positions 1..table_length and returns one transfer
//   on rsp_ch with found and match_position (0 when not found).
//   table_length is written over APB at address 0; searches cap it at TABLE_DEPTH.
// Search sequence:
//   A search is accepted, then each probe reads the key memory into a
//   register and then compares and updates the bounds; when no key matches,
//   the controller then finds the bounds crossed, and a last step loads the
//   response register. One request is in flight at a time; a load is taken
//   in the idle state and leaves the controller idle.
// Reset and stall:
//   Reset clears table_length and the controller; the key table is undefined
//   until written. A waiting response does not block req_ch: the next request
//   is taken, and a finished search holds in the controller until the response
//   register is free.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = stbs_pkg::KEY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  stbs_req_if.sink                           req_ch,
  stbs_rsp_if.source                         rsp_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [stbs_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [stbs_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [stbs_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import stbs_pkg::*;

  stbs_cmd_t           cmd;
  stbs_status_t        status;
  logic [LEN_BITS-1:0] table_length;

  stbs_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .table_length_o (table_length)
  );

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_ch.valid),
    .req_type_i  (req_ch.req_type),
    .req_ready_o (req_ch.ready),
    .rsp_valid_o (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .table_length_i   (table_length),
    .entry_position_i (req_ch.entry_position),
    .key_value_i      (req_ch.key_value),
    .found_o          (rsp_ch.found),
    .match_position_o (rsp_ch.match_position)
  );
endmodule

// ===== sim/sorted_table_binary_search_tb.sv =====
// Testbench for sorted_table_binary_search: directed and random loads and searches, checked by a predictor.
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int MAX_POS       = (1 << POS_BITS) - 1;
  localparam int SETTLE_CYCLES = 40;

  typedef logic        [POS_BITS-1:0]       pos_t;
  typedef logic signed [KEY_VALUE_BITS-1:0] key_t;

  typedef struct {
    logic found;
    pos_t position;
  } search_answer_t;

  typedef enum {DO_LOAD, DO_SEARCH, DO_SET_LEN} stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    int unsigned arg;
    key_t        key;
    bit          typed;
    logic        found;
    pos_t        where;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  stbs_req_if req_bus ();
  stbs_rsp_if rsp_bus ();

  sorted_table_binary_search DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_ch  (req_bus),
    .rsp_ch  (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  key_t           key_model [1:TABLE_DEPTH];
  int unsigned    len_model;
  search_answer_t pending_answers [$];
  stim_row_t      directed_rows [$];
  int             answers_seen;
  int             mismatches;
  bit             idle_on;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic search_answer_t find_key(input key_t key);
    search_answer_t ans;
    int lo;
    int hi;
    int mid;
    lo = 1;
    hi = (len_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_model);
    ans.found = 1'b0;
    ans.position = '0;
    while (lo <= hi && !ans.found) begin
      mid = (lo + hi) / 2;
      if (key_model[mid] == key) begin
        ans.found = 1'b1;
        ans.position = pos_t'(mid);
      end else if (key_model[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  function automatic void add_row(input stim_kind_e kind, input int unsigned arg,
                                  input key_t key, input bit typed = 1'b0,
                                  input logic found = 1'b0, input int unsigned where = 0);
    stim_row_t row;
    row.kind  = kind;
    row.arg   = arg;
    row.key   = key;
    row.typed = typed;
    row.found = found;
    row.where = pos_t'(where);
    directed_rows.push_back(row);
  endfunction

  task automatic send_req(input logic kind, input pos_t pos, input key_t key,
                          input bit typed = 1'b0, input logic found = 1'b0,
                          input pos_t where = '0);
    search_answer_t ans;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req_bus.valid          <= 1'b1;
    req_bus.req_type       <= kind;
    req_bus.entry_position <= pos;
    req_bus.key_value      <= key;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    if (kind == REQ_LOAD) begin
      if (pos >= 1 && pos <= TABLE_DEPTH) key_model[pos] = key;
    end else begin
      if (typed) begin
        ans.found = found;
        ans.position = where;
      end else begin
        ans = find_key(key);
      end
      pending_answers.push_back(ans);
    end
  endtask

  task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_TABLE_LENGTH) len_model = data[LEN_BITS-1:0];
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_answer();
    search_answer_t ans;
    answers_seen++;
    if (pending_answers.size() == 0) begin
      $error("unexpected result transfer: found %0d match_position %0d",
             rsp_bus.found, rsp_bus.match_position);
      mismatches++;
    end else begin
      ans = pending_answers.pop_front();
      if (rsp_bus.found !== ans.found) begin
        $error("found: expected %0d, got %0d", ans.found, rsp_bus.found);
        mismatches++;
      end
      if (rsp_bus.match_position !== ans.position) begin
        $error("match_position: expected %0d, got %0d", ans.position,
               rsp_bus.match_position);
        mismatches++;
      end
    end
  endtask

  // set the length, optionally refill 1..len (capped at TABLE_DEPTH) with ascending keys, then mix traffic
  task automatic run_phase(input int unsigned len_value, input bit refill, input int ops);
    int          slot [$];
    int          span;
    int          pick;
    int          j;
    int          k;
    int          tmp;
    longint      acc;
    longint      step_max;
    key_t        probe_key;
    pos_t        pos;
    drain();
    apb_write(REG_TABLE_LENGTH, len_value);
    span = (len_value > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_value);
    if (refill && span > 0) begin
      for (j = 1; j <= span; j++) slot.push_back(j);
      for (j = span - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        tmp = slot[j];
        slot[j] = slot[k];
        slot[k] = tmp;
      end
      step_max = 64'h1_0000_0000 / (span + 1);
      acc = -64'sd2147483648;
      for (j = 1; j <= span; j++) begin
        acc += $urandom_range(1, int'(step_max));
        key_model[j] = key_t'(acc);
      end
      // loads go out in shuffled order; key_model already holds the target keys
      foreach (slot[j]) send_req(REQ_LOAD, pos_t'(slot[j]), key_model[slot[j]]);
    end
    for (j = 0; j < ops; j++) begin
      pick = $urandom_range(0, 99);
      pos = pos_t'($urandom);
      if (pick < 55 && span > 0) begin
        send_req(REQ_SEARCH, pos, key_model[$urandom_range(1, span)]);
      end else if (pick < 70 && span > 0) begin
        probe_key = key_model[$urandom_range(1, span)];
        probe_key = $urandom_range(0, 1) ? probe_key + 1 : probe_key - 1;
        send_req(REQ_SEARCH, pos, probe_key);
      end else if (pick < 85) begin
        send_req(REQ_SEARCH, pos, key_t'($urandom));
      end else if (pick < 93) begin
        send_req(REQ_LOAD, pos_t'($urandom_range(1, TABLE_DEPTH)), key_t'($urandom));
      end else begin
        pos = $urandom_range(0, 1) ? pos_t'(0) : pos_t'($urandom_range(TABLE_DEPTH + 1, MAX_POS));
        send_req(REQ_LOAD, pos, key_t'($urandom));
      end
    end
  endtask

  initial begin : rsp_side
    int stall_left;
    int calm_left;
    bit held_once;
    stall_left = 0;
    calm_left  = 0;
    held_once  = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) check_answer();
      if (!held_once && answers_seen >= 100) begin
        // long hold-off so the request side backs up
        held_once = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && calm_left == 0 && idle_on) begin
        case ($urandom_range(0, 15))
          0, 1: stall_left = $urandom_range(1, 10);
          2: calm_left = $urandom_range(20, 120);
          default: ;
        endcase
      end
      if (calm_left > 0) calm_left--;
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : req_side
    answers_seen = 0;
    mismatches   = 0;
    idle_on      = 1'b1;
    len_model    = 0;
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_bus.valid          <= 1'b0;
    req_bus.req_type       <= REQ_LOAD;
    req_bus.entry_position <= '0;
    req_bus.key_value      <= '0;

    add_row(DO_SEARCH, MAX_POS, 0, 1'b1, 1'b0, 0);
    add_row(DO_LOAD, 0, 99);
    add_row(DO_LOAD, MAX_POS, 99);
    add_row(DO_LOAD, TABLE_DEPTH + 1, 99);
    add_row(DO_LOAD, 1, key_t'(32'h8000_0000));
    add_row(DO_LOAD, 2, -1);
    add_row(DO_LOAD, 3, 0);
    add_row(DO_LOAD, 4, 1);
    add_row(DO_LOAD, 5, key_t'(32'h7FFF_FFFF));
    add_row(DO_SET_LEN, 5, 0);
    add_row(DO_SEARCH, 0, key_t'(32'h8000_0000), 1'b1, 1'b1, 1);
    add_row(DO_SEARCH, 1024, key_t'(32'h7FFF_FFFF), 1'b1, 1'b1, 5);
    add_row(DO_SEARCH, 3, 0, 1'b1, 1'b1, 3);
    add_row(DO_SEARCH, MAX_POS, -1, 1'b1, 1'b1, 2);
    add_row(DO_SEARCH, 0, 1, 1'b1, 1'b1, 4);
    add_row(DO_SEARCH, 0, 99, 1'b1, 1'b0, 0);
    add_row(DO_SEARCH, 0, key_t'(32'h8000_0001), 1'b1, 1'b0, 0);
    add_row(DO_LOAD, 3, 50);
    add_row(DO_SEARCH, 0, 50);
    add_row(DO_SEARCH, 0, 1);
    add_row(DO_SET_LEN, 1, 0);
    add_row(DO_SEARCH, 0, key_t'(32'h8000_0000), 1'b1, 1'b1, 1);
    add_row(DO_SEARCH, 0, key_t'(32'h7FFF_FFFF), 1'b1, 1'b0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        DO_SET_LEN: begin
          drain();
          apb_write(REG_TABLE_LENGTH, directed_rows[i].arg);
        end
        DO_LOAD: begin
          send_req(REQ_LOAD, pos_t'(directed_rows[i].arg), directed_rows[i].key);
        end
        default: begin
          send_req(REQ_SEARCH, pos_t'(directed_rows[i].arg), directed_rows[i].key,
                   directed_rows[i].typed, directed_rows[i].found, directed_rows[i].where);
        end
      endcase
    end

    run_phase(1, 1'b1, 30);
    run_phase(2, 1'b1, 30);
    run_phase($urandom_range(3, 60), 1'b1, 100);
    run_phase($urandom_range(20, 100), 1'b1, 80);
    run_phase(TABLE_DEPTH, 1'b1, 120);
    run_phase(MAX_POS, 1'b0, 60);
    run_phase(0, 1'b0, 15);
    drain();
    idle_on = 1'b0;
    run_phase($urandom_range(1, TABLE_DEPTH), 1'b0, 80);
    drain();

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
